// ===== sv/assert_macros.svh =====
// Assertion macros used by the scaler's port-level checker.
// CHK_ASSERT checks that a property holds at every clock edge out of reset.
// CHK_NEVER checks that a condition is never seen at a clock edge out of reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define CHK_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define CHK_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== sv/nxs_pkg.sv =====
// ----------------------------------------------------------------------------
// nxs_pkg
// Types and constants shared by the NV12 to XRGB nearest-neighbor scaler.
// ----------------------------------------------------------------------------
package nxs_pkg;

	// Configuration register indexes.
	localparam logic [2:0] REG_SRC_WIDTH   = 3'd0;
	localparam logic [2:0] REG_SRC_HEIGHT  = 3'd1;
	localparam logic [2:0] REG_LINE_STRIDE = 3'd2;
	localparam logic [2:0] REG_DST_WIDTH   = 3'd3;
	localparam logic [2:0] REG_DST_HEIGHT  = 3'd4;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 13;
	localparam int SRC_W      = 7;   // source size and stride registers
	localparam int DST_W      = 13;  // destination size registers
	localparam int COORD_W    = 12;
	localparam int BADDR_W    = 13;
	localparam int PIX_W      = 24;
	localparam int QUO_W      = 7;   // source coordinate, always below src size
	localparam int REM_W      = 20;  // dividend and partial remainder
	localparam int ADDR_W     = 16;  // frame store addresses from the address stage
	localparam int UVB_W      = 14;  // stride times source height
	localparam int SUM_W      = 20;  // signed color sums

	localparam int QUEUE_DEPTH = 16;
	localparam int OUT_DEPTH   = 8;

	// BT.601 limited-range coefficients.
	localparam logic signed [SUM_W-1:0] K_Y   = 20'sd298;
	localparam logic signed [SUM_W-1:0] K_RV  = 20'sd409;
	localparam logic signed [SUM_W-1:0] K_GU  = 20'sd100;
	localparam logic signed [SUM_W-1:0] K_GV  = 20'sd208;
	localparam logic signed [SUM_W-1:0] K_BU  = 20'sd516;
	localparam logic signed [SUM_W-1:0] K_RND = 20'sd128;
	localparam logic signed [9:0] Y_OFS  = 10'sd16;
	localparam logic signed [9:0] UV_OFS = 10'sd128;

	typedef enum logic [1:0] {
		KIND_WRITE,
		KIND_CONVERT,
		KIND_DROP
	} kind_t;

	typedef struct packed {
		logic [SRC_W-1:0] src_width;
		logic [SRC_W-1:0] src_height;
		logic [SRC_W-1:0] line_stride;
		logic [DST_W-1:0] dst_width;
		logic [DST_W-1:0] dst_height;
		logic [UVB_W-1:0] uv_base;
	} cfg_t;

	// One classified item on its way from the front to the back.
	typedef struct packed {
		kind_t             kind;
		logic [ADDR_W-1:0] yaddr;   // luma address, or the byte address of a write
		logic [ADDR_W-1:0] uvaddr;
		logic [7:0]        value;
		logic [PIX_W-1:0]  pixel_index;
	} qent_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_index;
		logic [PIX_W-1:0] rgb_word;
	} oent_t;

endpackage

// ===== sv/nxs_req_if.sv =====
// ----------------------------------------------------------------------------
// nxs_req_if
// Request channel: byte writes and convert items.
// ----------------------------------------------------------------------------
interface nxs_req_if;
	logic        valid;
	logic        ready;
	logic        action;
	logic [12:0] byte_address;
	logic [7:0]  byte_value;
	logic [11:0] out_x;
	logic [11:0] out_y;

	modport source(output valid, action, byte_address, byte_value, out_x, out_y,
		input ready);
	modport sink(input valid, action, byte_address, byte_value, out_x, out_y,
		output ready);
endinterface

// ===== sv/nxs_rsp_if.sv =====
// ----------------------------------------------------------------------------
// nxs_rsp_if
// Result channel: converted pixels with their destination index.
// ----------------------------------------------------------------------------
interface nxs_rsp_if;
	logic        valid;
	logic        ready;
	logic [23:0] pixel_index;
	logic [23:0] rgb_word;

	modport source(output valid, pixel_index, rgb_word, input ready);
	modport sink(input valid, pixel_index, rgb_word, output ready);
endinterface

// ===== sv/nxs_fifo.sv =====
// ----------------------------------------------------------------------------
// nxs_fifo
// Small flip-flop queue with a count; the writer guarantees it never overflows.
// ----------------------------------------------------------------------------
module nxs_fifo #(
	parameter int DEPTH = 16,
	parameter type T = logic
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  T     push_data,
	input  logic pop,
	output logic not_empty,
	output T     pop_data
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	T                 mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign not_empty = (count_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end
endmodule

// ===== sv/nxs_front.sv =====
// ----------------------------------------------------------------------------
// nxs_front
// Accepts items, classifies them, scales the coordinates with a pipelined
// one-bit-per-stage divider and forms the frame store addresses.
// ----------------------------------------------------------------------------
module nxs_front
	import nxs_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	nxs_req_if.sink req,
	output logic  push,
	output qent_t push_data,
	input  logic  pop
);
	localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

	logic             acc;
	logic             in_range;
	logic [OCC_W-1:0] occ_q;

	// Divider stage 0 is the accept register; stage QUO_W holds the quotients.
	logic [QUO_W:0]     div_v_q;
	kind_t              div_kind_q  [QUO_W+1];
	logic [BADDR_W-1:0] div_addr_q  [QUO_W+1];
	logic [7:0]         div_val_q   [QUO_W+1];
	logic [PIX_W-1:0]   div_pix_q   [QUO_W+1];
	logic [REM_W-1:0]   div_rx_q    [QUO_W+1];
	logic [REM_W-1:0]   div_ry_q    [QUO_W+1];
	logic [QUO_W-1:0]   div_qx_q    [QUO_W+1];
	logic [QUO_W-1:0]   div_qy_q    [QUO_W+1];

	logic [QUO_W-1:0] sx;
	logic [QUO_W-1:0] sy;

	// Items in flight or queued; the queue can never overflow.
	assign req.ready = (occ_q < OCC_W'(QUEUE_DEPTH));
	assign acc       = req.valid & req.ready;
	assign in_range  = ({1'b0, req.out_x} < cfg.dst_width) &&
		({1'b0, req.out_y} < cfg.dst_height);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else begin
			occ_q <= occ_q + OCC_W'(acc) - OCC_W'(pop);
		end
	end

	// Accept stage: classify, form dividends and the destination index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_v_q[0] <= 1'b0;
		end else begin
			div_v_q[0] <= acc;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			if (!req.action) begin
				div_kind_q[0] <= KIND_WRITE;
			end else if (in_range) begin
				div_kind_q[0] <= KIND_CONVERT;
			end else begin
				div_kind_q[0] <= KIND_DROP;
			end
			div_addr_q[0] <= req.byte_address;
			div_val_q[0]  <= req.byte_value;
			div_pix_q[0]  <= PIX_W'(req.out_y) * PIX_W'(cfg.dst_width) + PIX_W'(req.out_x);
			div_rx_q[0]   <= REM_W'(req.out_x) * REM_W'(cfg.src_width);
			div_ry_q[0]   <= REM_W'(req.out_y) * REM_W'(cfg.src_height);
			div_qx_q[0]   <= '0;
			div_qy_q[0]   <= '0;
		end
	end

	// Restoring division, one quotient bit per stage, most significant first.
	for (genvar j = 1; j <= QUO_W; j++) begin : g_div
		localparam int B = QUO_W - j;
		logic [REM_W-1:0] dx;
		logic [REM_W-1:0] dy;
		logic             gex;
		logic             gey;

		assign dx  = REM_W'(cfg.dst_width) << B;
		assign dy  = REM_W'(cfg.dst_height) << B;
		assign gex = div_rx_q[j-1] >= dx;
		assign gey = div_ry_q[j-1] >= dy;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_v_q[j] <= 1'b0;
			end else begin
				div_v_q[j] <= div_v_q[j-1];
			end
		end

		always_ff @(posedge clk) begin
			div_kind_q[j] <= div_kind_q[j-1];
			div_addr_q[j] <= div_addr_q[j-1];
			div_val_q[j]  <= div_val_q[j-1];
			div_pix_q[j]  <= div_pix_q[j-1];
			div_rx_q[j]   <= gex ? div_rx_q[j-1] - dx : div_rx_q[j-1];
			div_ry_q[j]   <= gey ? div_ry_q[j-1] - dy : div_ry_q[j-1];
			div_qx_q[j]   <= div_qx_q[j-1] | (QUO_W'(gex) << B);
			div_qy_q[j]   <= div_qy_q[j-1] | (QUO_W'(gey) << B);
		end
	end

	assign sx = div_qx_q[QUO_W];
	assign sy = div_qy_q[QUO_W];

	// Address stage: luma and chroma addresses of the chosen source pixel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else begin
			push <= div_v_q[QUO_W];
		end
	end

	always_ff @(posedge clk) begin
		push_data.kind        <= div_kind_q[QUO_W];
		push_data.value       <= div_val_q[QUO_W];
		push_data.pixel_index <= div_pix_q[QUO_W];
		if (div_kind_q[QUO_W] == KIND_WRITE) begin
			push_data.yaddr <= ADDR_W'(div_addr_q[QUO_W]);
		end else begin
			push_data.yaddr <= ADDR_W'(sy) * ADDR_W'(cfg.line_stride) + ADDR_W'(sx);
		end
		push_data.uvaddr <= ADDR_W'(cfg.uv_base)
			+ ADDR_W'(sy[QUO_W-1:1]) * ADDR_W'(cfg.line_stride)
			+ ADDR_W'({sx[QUO_W-1:1], 1'b0});
	end
endmodule

// ===== sv/nxs_back.sv =====
// ----------------------------------------------------------------------------
// nxs_back
// Holds the frame store, carries out writes, fetches Y, U and V, converts to
// RGB and queues the results for the output channel.
// ----------------------------------------------------------------------------
module nxs_back
	import nxs_pkg::*;
#(
	parameter int STORE_DEPTH = 6144
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  q_valid,
	input  qent_t q_data,
	output logic  q_pop,
	nxs_rsp_if.source rsp
);
	localparam int IDX_W = $clog2(STORE_DEPTH);
	localparam int OCC_W = $clog2(OUT_DEPTH + 1);

	// Two copies of the store give three reads per item.
	logic [7:0] mem_a [STORE_DEPTH];
	logic [7:0] mem_b [STORE_DEPTH];

	logic [ADDR_W-1:0] vaddr;
	logic              wr_ok;
	logic              rd_conv;
	logic              rsp_acc;
	logic [OCC_W-1:0]  occ_q;

	logic              v_s1;
	logic [PIX_W-1:0]  pix_s1;
	logic              yok_s1;
	logic              uok_s1;
	logic              vok_s1;
	logic [7:0]        y_s1;
	logic [7:0]        u_s1;
	logic [7:0]        v_dat_s1;

	logic signed [9:0]       c;
	logic signed [9:0]       d;
	logic signed [9:0]       e;
	logic signed [SUM_W-1:0] cw;
	logic signed [SUM_W-1:0] dw;
	logic signed [SUM_W-1:0] ew;

	logic                    v_s2;
	logic [PIX_W-1:0]        pix_s2;
	logic signed [SUM_W-1:0] r_s2;
	logic signed [SUM_W-1:0] g_s2;
	logic signed [SUM_W-1:0] b_s2;

	logic  v_s3;
	oent_t out_s3;
	oent_t out_head;
	logic  out_ne;

	function automatic logic [7:0] clamp8(input logic signed [SUM_W-1:0] s);
		logic [7:0] res;
		if (s[SUM_W-1]) begin
			res = 8'd0;
		end else if (s[SUM_W-2:8] > (SUM_W-9)'(255)) begin
			res = 8'd255;
		end else begin
			res = s[15:8];
		end
		return res;
	endfunction

	// Take a queued item only while the result queue has room for it.
	assign q_pop   = q_valid && (occ_q < OCC_W'(OUT_DEPTH));
	assign rd_conv = q_pop && (q_data.kind == KIND_CONVERT);
	assign wr_ok   = q_pop && (q_data.kind == KIND_WRITE) &&
		(32'(q_data.yaddr) < STORE_DEPTH);
	assign vaddr   = q_data.uvaddr + 1'b1;
	assign rsp_acc = rsp.valid & rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else begin
			occ_q <= occ_q + OCC_W'(rd_conv) - OCC_W'(rsp_acc);
		end
	end

	// Frame store: write port and registered reads.
	always_ff @(posedge clk) begin
		if (wr_ok) begin
			mem_a[IDX_W'(q_data.yaddr)] <= q_data.value;
			mem_b[IDX_W'(q_data.yaddr)] <= q_data.value;
		end
		y_s1     <= mem_a[IDX_W'(q_data.yaddr)];
		u_s1     <= mem_a[IDX_W'(q_data.uvaddr)];
		v_dat_s1 <= mem_b[IDX_W'(vaddr)];
	end

	// Fetch stage control; fetches beyond the store read as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= rd_conv;
		end
	end

	always_ff @(posedge clk) begin
		pix_s1 <= q_data.pixel_index;
		yok_s1 <= 32'(q_data.yaddr) < STORE_DEPTH;
		uok_s1 <= 32'(q_data.uvaddr) < STORE_DEPTH;
		vok_s1 <= 32'(vaddr) < STORE_DEPTH;
	end

	// Color sums.
	assign c  = signed'({2'b00, yok_s1 ? y_s1 : 8'd0}) - Y_OFS;
	assign d  = signed'({2'b00, uok_s1 ? u_s1 : 8'd0}) - UV_OFS;
	assign e  = signed'({2'b00, vok_s1 ? v_dat_s1 : 8'd0}) - UV_OFS;
	assign cw = SUM_W'(c);
	assign dw = SUM_W'(d);
	assign ew = SUM_W'(e);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		pix_s2 <= pix_s1;
		r_s2   <= K_Y * cw + K_RV * ew + K_RND;
		g_s2   <= K_Y * cw - K_GU * dw - K_GV * ew + K_RND;
		b_s2   <= K_Y * cw + K_BU * dw + K_RND;
	end

	// Clamp and pack.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		out_s3.pixel_index <= pix_s2;
		out_s3.rgb_word    <= {clamp8(r_s2), clamp8(g_s2), clamp8(b_s2)};
	end

	// Result queue toward the output channel.
	nxs_fifo #(
		.DEPTH(OUT_DEPTH),
		.T(oent_t)
	) u_out_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(v_s3),
		.push_data(out_s3),
		.pop(rsp_acc),
		.not_empty(out_ne),
		.pop_data(out_head)
	);

	assign rsp.valid       = out_ne;
	assign rsp.pixel_index = out_head.pixel_index;
	assign rsp.rgb_word    = out_head.rgb_word;
endmodule

// ===== sv/nv12_to_xrgb_nearest_scaler.sv =====
// ----------------------------------------------------------------------------
// nv12_to_xrgb_nearest_scaler
// NV12 frame store with nearest-neighbor scaling and BT.601 RGB conversion.
//
//   channel | dir | handshake         | carries
//   req     | in  | valid/ready       | action, byte_address, byte_value, out_x, out_y
//   rsp     | out | valid/ready       | pixel_index, rgb_word
//   cfg     | in  | cfg_we            | cfg_index, cfg_data
//
// One item is taken every clock while req.ready is high. A convert item's
// result passes through the accept register, seven divider stages, the
// address stage, the queue write, the store read, the color sums, the clamp
// stage and the result queue write, in that order, before it is offered on rsp.
// Reset clears all control state; the frame store holds nothing until written
// and needs no clearing pass.
// A stalled result side fills the result queue, then the central queue, and
// only then drops req.ready.
// ----------------------------------------------------------------------------
module nv12_to_xrgb_nearest_scaler
	import nxs_pkg::*;
#(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	nxs_req_if.sink               req,
	nxs_rsp_if.source             rsp,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);
	localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT * 3 / 2;

	cfg_t  cfg_q;
	logic  push;
	qent_t push_data;
	logic  q_valid;
	qent_t q_data;
	logic  q_pop;

	// Configuration registers; the chroma base follows them.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.src_width   <= SRC_W'(64);
			cfg_q.src_height  <= SRC_W'(64);
			cfg_q.line_stride <= SRC_W'(64);
			cfg_q.dst_width   <= DST_W'(64);
			cfg_q.dst_height  <= DST_W'(64);
			cfg_q.uv_base     <= UVB_W'(4096);
		end else begin
			cfg_q.uv_base <= UVB_W'(cfg_q.line_stride) * UVB_W'(cfg_q.src_height);
			if (cfg_we) begin
				case (cfg_index)
					REG_SRC_WIDTH:   cfg_q.src_width   <= cfg_data[SRC_W-1:0];
					REG_SRC_HEIGHT:  cfg_q.src_height  <= cfg_data[SRC_W-1:0];
					REG_LINE_STRIDE: cfg_q.line_stride <= cfg_data[SRC_W-1:0];
					REG_DST_WIDTH:   cfg_q.dst_width   <= cfg_data[DST_W-1:0];
					REG_DST_HEIGHT:  cfg_q.dst_height  <= cfg_data[DST_W-1:0];
					default: begin
					end
				endcase
			end
		end
	end

	nxs_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.req(req),
		.push(push),
		.push_data(push_data),
		.pop(q_pop)
	);

	nxs_fifo #(
		.DEPTH(QUEUE_DEPTH),
		.T(qent_t)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data(push_data),
		.pop(q_pop),
		.not_empty(q_valid),
		.pop_data(q_data)
	);

	nxs_back #(
		.STORE_DEPTH(STORE_DEPTH)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(q_valid),
		.q_data(q_data),
		.q_pop(q_pop),
		.rsp(rsp)
	);
endmodule

// ===== sv/nxs_checker.sv =====
// ----------------------------------------------------------------------------
// nxs_checker
// Port-level checks on the scaler, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nxs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        req_action,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [23:0] rsp_pixel_index,
	input logic [23:0] rsp_rgb_word
);
	logic        conv_acc;
	logic        rsp_acc;
	logic        rsp_stall;
	logic [47:0] rsp_word;
	logic [31:0] pending_q;

	assign conv_acc  = req_valid & req_ready & req_action;
	assign rsp_acc   = rsp_valid & rsp_ready;
	assign rsp_stall = rsp_valid & ~rsp_ready;
	assign rsp_word  = {rsp_pixel_index, rsp_rgb_word};

	// Convert items taken and not yet answered (an upper bound on results owed).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + 32'(conv_acc) - 32'(rsp_acc);
		end
	end

	`CHK_ASSERT(a_rsp_hold, clk, arst_n, rsp_stall |=> rsp_valid, "result dropped while stalled")
	`CHK_ASSERT(a_rsp_stable, clk, arst_n, rsp_stall |=> $stable(rsp_word), "result changed")
	`CHK_NEVER(a_no_invented, clk, arst_n, rsp_valid && (pending_q == '0), "result not owed")
endmodule

bind nv12_to_xrgb_nearest_scaler nxs_checker u_nxs_checker (
	.clk(clk),
	.arst_n(arst_n),
	.req_valid(req.valid),
	.req_ready(req.ready),
	.req_action(req.action),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.rsp_pixel_index(rsp.pixel_index),
	.rsp_rgb_word(rsp.rgb_word)
);

// ===== test/nxs_checker.sv =====
// ----------------------------------------------------------------------------
// nxs_scoreboard
// Watches the request, result and configuration ports of the scaler.
// It keeps its own copy of the frame store and the registers, predicts
// the pixel of each accepted in-range convert, compares results in order.
// ----------------------------------------------------------------------------
module nxs_scoreboard
	import nxs_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	nxs_req_if                    req,
	nxs_rsp_if                    rsp,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    fail_count,
	output int                    pending,
	output int                    checked
);
	localparam int STORE_DEPTH = 64 * 64 * 3 / 2;

	logic [7:0]       shadow_store [STORE_DEPTH];
	logic [SRC_W-1:0] src_w, src_h, stride;
	logic [DST_W-1:0] dst_w, dst_h;
	oent_t            pixel_fifo [$];

	// Clamp a color sum after the floor shift by eight.
	function automatic logic [7:0] clamp_channel(int sum);
		if (sum < 0)
			return 8'd0;
		sum = sum / 256;
		if (sum > 255)
			return 8'd255;
		return sum[7:0];
	endfunction

	// Fetches beyond the store read as zero.
	function automatic int fetch_byte(int addr);
		if (addr >= STORE_DEPTH)
			return 0;
		return int'(shadow_store[addr]);
	endfunction

	// Work out the pixel for one in-range convert item and queue it.
	task automatic predict_pixel(int x, int y);
		int sx, sy, yaddr, uvaddr, c, d, e;
		oent_t px;
		if (x >= dst_w || y >= dst_h)
			return;
		sx = x * int'(src_w) / int'(dst_w);
		sy = y * int'(src_h) / int'(dst_h);
		yaddr = sy * int'(stride) + sx;
		uvaddr = int'(stride) * int'(src_h) + (sy / 2) * int'(stride) + (sx / 2) * 2;
		c = fetch_byte(yaddr) - 16;
		d = fetch_byte(uvaddr) - 128;
		e = fetch_byte(uvaddr + 1) - 128;
		px.pixel_index = PIX_W'(y * int'(dst_w) + x);
		px.rgb_word = {clamp_channel(298 * c + 409 * e + 128),
			clamp_channel(298 * c - 100 * d - 208 * e + 128),
			clamp_channel(298 * c + 516 * d + 128)};
		pixel_fifo.push_back(px);
	endtask

	// Ports are stable at the falling edge, so sample there what the next
	// rising edge will accept.
	always @(negedge clk or negedge arst_n) begin
		oent_t want;
		if (!arst_n) begin
			src_w = 7'd64;
			src_h = 7'd64;
			stride = 7'd64;
			dst_w = 13'd64;
			dst_h = 13'd64;
			pixel_fifo.delete();
			fail_count = 0;
			checked = 0;
		end else begin
			// Register writes.
			if (cfg_we) begin
				case (cfg_index)
					REG_SRC_WIDTH:   src_w = cfg_data[SRC_W-1:0];
					REG_SRC_HEIGHT:  src_h = cfg_data[SRC_W-1:0];
					REG_LINE_STRIDE: stride = cfg_data[SRC_W-1:0];
					REG_DST_WIDTH:   dst_w = cfg_data[DST_W-1:0];
					REG_DST_HEIGHT:  dst_h = cfg_data[DST_W-1:0];
					default: ;
				endcase
			end
			// Request items: writes update the store, converts are predicted.
			if (req.valid && req.ready) begin
				if (req.action == 1'b0) begin
					if (req.byte_address < STORE_DEPTH)
						shadow_store[req.byte_address] = req.byte_value;
				end else begin
					predict_pixel(int'(req.out_x), int'(req.out_y));
				end
			end
			// Result items against the oldest expectation.
			if (rsp.valid && rsp.ready) begin
				if (pixel_fifo.size() == 0) begin
					$display("%0t: unexpected result index %0d rgb %06h", $realtime,
						rsp.pixel_index, rsp.rgb_word);
					fail_count++;
				end else begin
					want = pixel_fifo.pop_front();
					checked++;
					if (rsp.pixel_index !== want.pixel_index) begin
						$display("%0t: pixel_index expected %0d actual %0d", $realtime,
							want.pixel_index, rsp.pixel_index);
						fail_count++;
					end
					if (rsp.rgb_word !== want.rgb_word) begin
						$display("%0t: rgb_word expected %06h actual %06h (index %0d)",
							$realtime, want.rgb_word, rsp.rgb_word, want.pixel_index);
						fail_count++;
					end
				end
			end
		end
		pending = pixel_fifo.size();
	end

endmodule

// ===== test/tb_nv12_to_xrgb_nearest_scaler.sv =====
// ----------------------------------------------------------------------------
// tb_nv12_to_xrgb_nearest_scaler
// Writes frame store bytes as the converts come to need them, runs a few
// directed pixels at the color and coordinate extremes, then steps through
// register settings (tiny, odd, zero and maximum sizes) with random writes
// and converts, random gaps on the request side and random stalls on the
// result side.
// ----------------------------------------------------------------------------
module tb_nv12_to_xrgb_nearest_scaler;
	import nxs_pkg::*;

	localparam int STORE_DEPTH = 6144;
	localparam int IDLE_LIMIT  = 3000;
	localparam int NUM_PHASES  = 11;
	localparam int PHASE_ITEMS = 56;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    fail_count, pending, checked;
	int                    items_sent, idle_cycles, stall_left;
	bit                    steady;

	// Bytes of the store written so far, and the registers now in force.
	bit written [STORE_DEPTH];
	int cur_regs [5] = '{64, 64, 64, 64, 64};

	// Source width, height, stride, destination width, height per phase.
	int phase_regs [NUM_PHASES][5] = '{
		'{2, 2, 2, 1, 1}, '{4, 4, 4, 8, 8}, '{16, 8, 20, 5, 3},
		'{64, 64, 64, 4096, 4096}, '{3, 5, 2, 7, 9}, '{0, 0, 0, 10, 10},
		'{10, 10, 127, 4095, 1}, '{127, 127, 127, 8191, 8191}, '{8, 8, 8, 0, 5},
		'{6, 4, 6, 1, 4096}, '{64, 64, 64, 64, 64}};

	nxs_req_if req_ch();
	nxs_rsp_if rsp_ch();

	nv12_to_xrgb_nearest_scaler uut (
		.clk(clk), .arst_n(arst_n), .req(req_ch), .rsp(rsp_ch),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	nxs_scoreboard u_scoreboard (
		.clk(clk), .arst_n(arst_n), .req(req_ch), .rsp(rsp_ch),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending), .checked(checked)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Result side: random stalls, mostly short, a few long; none when steady.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			stall_left = 0;
		end else if (steady) begin
			rsp_ch.ready <= 1'b1;
		end else if (stall_left > 0) begin
			rsp_ch.ready <= 1'b0;
			stall_left--;
		end else begin
			rsp_ch.ready <= 1'b1;
			case ($urandom_range(0, 99)) inside
				[0:19]:  stall_left = $urandom_range(1, 3);
				[20:22]: stall_left = $urandom_range(10, 40);
				default: ;
			endcase
		end
	end

	// Watchdog on cycles without any accepted item.
	always @(negedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: timeout, %0d pixels outstanding", $realtime, pending);
				$display("tb_nv12_to_xrgb_nearest_scaler NOT OK");
				$finish;
			end
		end
	end

	// Present one item and hold it until accepted, then maybe leave a gap.
	task automatic send_item(logic act, logic [12:0] addr, logic [7:0] value,
			logic [11:0] x, logic [11:0] y);
		int gap;
		req_ch.valid <= 1'b1;
		req_ch.action <= act;
		req_ch.byte_address <= addr;
		req_ch.byte_value <= value;
		req_ch.out_x <= x;
		req_ch.out_y <= y;
		@(negedge clk);
		while (!req_ch.ready)
			@(negedge clk);
		@(posedge clk);
		items_sent++;
		gap = 0;
		if (!steady) begin
			case ($urandom_range(0, 99)) inside
				[0:29]:  gap = $urandom_range(1, 3);
				[30:33]: gap = $urandom_range(10, 40);
				default: ;
			endcase
		end
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic write_byte(int addr, int value);
		if (addr < STORE_DEPTH)
			written[addr] = 1'b1;
		send_item(1'b0, 13'(addr), 8'(value), 12'($urandom), 12'($urandom));
	endtask

	// A convert first writes any byte of the store it will fetch that has
	// never been written.
	task automatic convert(int x, int y);
		int sx, sy;
		int fa [3];
		if (x < cur_regs[3] && y < cur_regs[4]) begin
			sx = x * cur_regs[0] / cur_regs[3];
			sy = y * cur_regs[1] / cur_regs[4];
			fa[0] = sy * cur_regs[2] + sx;
			fa[1] = cur_regs[2] * cur_regs[1] + (sy / 2) * cur_regs[2] + (sx / 2) * 2;
			fa[2] = fa[1] + 1;
			foreach (fa[k]) begin
				if (fa[k] < STORE_DEPTH && !written[fa[k]])
					write_byte(fa[k], $urandom_range(0, 255));
			end
		end
		send_item(1'b1, 13'($urandom), 8'($urandom), 12'(x), 12'(y));
	endtask

	// Let every expected pixel out, then give trailing writes time to settle.
	task automatic drain();
		req_ch.valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (20) @(posedge clk);
	endtask

	// Write all five registers, one per cycle.
	task automatic program_regs(int p);
		for (int i = 0; i < 5; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= CFG_IDX_W'(i);
			cfg_data <= CFG_DATA_W'(phase_regs[p][i]);
			cur_regs[i] = (i < 3) ? (phase_regs[p][i] & 127) : (phase_regs[p][i] & 8191);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	initial begin
		int dw, dh, x, y, start;
		req_ch.valid = 1'b0;
		req_ch.action = 1'b0;
		req_ch.byte_address = '0;
		req_ch.byte_value = '0;
		req_ch.out_x = '0;
		req_ch.out_y = '0;
		rsp_ch.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		items_sent = 0;
		idle_cycles = 0;
		steady = 1'b0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed pixels at reset sizes; the chroma plane starts at 4096.
		write_byte(0, 255); write_byte(4096, 255); write_byte(4097, 255);
		convert(0, 0);
		write_byte(0, 0); write_byte(4096, 0); write_byte(4097, 0);
		convert(0, 0);
		write_byte(0, 16); write_byte(4096, 128); write_byte(4097, 128);
		convert(0, 0);
		convert(63, 63); convert(63, 0); convert(0, 63);
		// Outside the destination.
		convert(64, 0); convert(0, 64); convert(4095, 4095);
		// Writes beyond the store are ignored.
		write_byte(6144, 77); write_byte(8191, 200);
		convert(0, 0);
		drain();

		// Random items under each register setting.
		for (int p = 0; p < NUM_PHASES; p++) begin
			steady = (p % 4 == 3);
			program_regs(p);
			dw = phase_regs[p][3];
			dh = phase_regs[p][4];
			start = items_sent;
			while (items_sent - start < PHASE_ITEMS) begin
				if ($urandom_range(0, 99) < 30) begin
					if ($urandom_range(0, 9) == 0)
						write_byte($urandom_range(STORE_DEPTH, 8191), $urandom_range(0, 255));
					else
						write_byte($urandom_range(0, STORE_DEPTH - 1), $urandom_range(0, 255));
				end else begin
					if (dw > 0 && $urandom_range(0, 99) < 85)
						x = $urandom_range(0, (dw > 4096 ? 4096 : dw) - 1);
					else
						x = $urandom_range(0, 4095);
					if (dh > 0 && $urandom_range(0, 99) < 85)
						y = $urandom_range(0, (dh > 4096 ? 4096 : dh) - 1);
					else
						y = $urandom_range(0, 4095);
					convert(x, y);
				end
			end
			drain();
		end
		steady = 1'b0;

		$display("Sent %0d items over %0d register settings; %0d pixels compared.",
			items_sent, NUM_PHASES + 1, checked);
		if (fail_count == 0) begin
			$display("tb_nv12_to_xrgb_nearest_scaler OK");
		end else begin
			$display("%0d mismatches found.", fail_count);
			$display("tb_nv12_to_xrgb_nearest_scaler NOT OK");
		end
		$finish;
	end

endmodule
